// ===== rtl/core/hsfd_pkg.sv =====
// Shared constants, status codes and checksum/scaling functions for the frame decoder.
`timescale 1ns / 1ps

package hsfd_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned CHECK_W    = 8;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned TEMP_W     = 15;
    localparam int unsigned HUM_W      = 14;
    localparam int unsigned PROD_W     = 31;
    localparam int unsigned QUOT_W     = PROD_W - WORD_W;

    localparam logic [CHECK_W-1:0]  CRC_POLY    = 8'h31;
    localparam logic [CHECK_W-1:0]  CRC_INIT    = 8'hFF;
    localparam logic [WORD_W-1:0]   FULL_SCALE  = 16'hFFFF;
    localparam logic [PROD_W-WORD_W-1:0] TEMP_SPAN = 15'd17500;
    localparam logic [PROD_W-WORD_W-1:0] HUM_SPAN  = 15'd10000;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = -15'sd4500;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_TEMP_BAD = 2'd1,
        ST_HUM_BAD  = 2'd2
    } t_status;

    // One byte through the CRC-8 shift register, MSB first.
    function automatic logic [CHECK_W-1:0] crc8_byte(input logic [CHECK_W-1:0] crc,
                                                     input logic [CHECK_W-1:0] data);
        logic [CHECK_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[CHECK_W-1]) begin
                c = {c[CHECK_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CHECK_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Checksum of a 16-bit word, high byte first.
    function automatic logic [CHECK_W-1:0] word_crc(input logic [WORD_W-1:0] w);
        return crc8_byte(crc8_byte(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // floor(x / 65535) for x below 65535 * 2^15: take x >> 16 as the first
    // estimate, the remainder is then (x mod 2^16) + estimate, which stays
    // under twice the divisor, so one compare fixes the quotient.
    function automatic logic [QUOT_W-1:0] div_full_scale(input logic [PROD_W-1:0] x);
        logic [QUOT_W-1:0] q0;
        logic [WORD_W:0]   rem;
        q0  = x[PROD_W-1:WORD_W];
        rem = {1'b0, x[WORD_W-1:0]} + {{(WORD_W+1-QUOT_W){1'b0}}, q0};
        if (rem >= {1'b0, FULL_SCALE}) begin
            return q0 + {{(QUOT_W-1){1'b0}}, 1'b1};
        end else begin
            return q0;
        end
    endfunction

endpackage

// ===== rtl/core/hsfd_in_if.sv =====
// Input channel carrying one raw measurement frame per transaction.
`timescale 1ns / 1ps

interface hsfd_in_if;
    logic                           valid;
    logic                           ready;
    logic [hsfd_pkg::WORD_W-1:0]    temp_word;
    logic [hsfd_pkg::CHECK_W-1:0]   temp_check;
    logic [hsfd_pkg::WORD_W-1:0]    hum_word;
    logic [hsfd_pkg::CHECK_W-1:0]   hum_check;

    modport source (output valid, output temp_word, output temp_check,
                    output hum_word, output hum_check, input ready);
    modport sink   (input valid, input temp_word, input temp_check,
                    input hum_word, input hum_check, output ready);
endinterface

// ===== rtl/core/hsfd_out_if.sv =====
// Output channel carrying one decoded measurement per transaction.
`timescale 1ns / 1ps

interface hsfd_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [hsfd_pkg::STATUS_W-1:0]         status;
    logic signed [hsfd_pkg::TEMP_W-1:0]    temp_centi;
    logic [hsfd_pkg::HUM_W-1:0]            hum_centi;

    modport source (output valid, output status, output temp_centi,
                    output hum_centi, input ready);
    modport sink   (input valid, input status, input temp_centi,
                    input hum_centi, output ready);
endinterface

// ===== rtl/core/humidity_sensor_frame_decoder.sv =====
// Top level: checksum check and unit scaling of temperature/humidity frames.
//
// Usage:
//   i_in  takes one transaction per frame: raw temperature word and its CRC-8
//         byte, raw humidity word and its CRC-8 byte (poly 0x31, init 0xFF).
//   o_out returns one transaction per frame: status (ok, temperature bad,
//         humidity bad; temperature is checked first), temperature in
//         hundredths of a degree C and humidity in hundredths of a percent.
//         Both values read zero when a checksum fails.
//   Path: the input transaction is captured in the input register, then
//   passes through CRC, constant multiply and divide-by-65535 correction
//   into the result register, which drives o_out.valid.
//   Throughput: one frame per cycle while o_out.ready is high; the two
//   register stages form a valid/ready pipeline, so a new frame is taken
//   while a result waits as long as the input register is empty.
//   Stall: when o_out.ready is low the result register holds; the input
//   register still fills if empty, then i_in.ready drops until the output
//   drains. No transaction is lost or repeated.
//   Reset (i_rst_n low, synchronous): both stages empty, o_out.valid low.
`timescale 1ns / 1ps

module humidity_sensor_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsfd_in_if.sink     i_in,
    hsfd_out_if.source  o_out
);

    // Input register stage.
    logic                           r_s1_valid;
    logic [hsfd_pkg::WORD_W-1:0]    r_s1_temp_word;
    logic [hsfd_pkg::CHECK_W-1:0]   r_s1_temp_check;
    logic [hsfd_pkg::WORD_W-1:0]    r_s1_hum_word;
    logic [hsfd_pkg::CHECK_W-1:0]   r_s1_hum_check;

    // Result register stage.
    logic                                  r_s2_valid;
    hsfd_pkg::t_status                     r_s2_status;
    logic signed [hsfd_pkg::TEMP_W-1:0]    r_s2_temp_centi;
    logic [hsfd_pkg::HUM_W-1:0]            r_s2_hum_centi;

    logic                                  s1_advance;
    logic                                  in_take;
    hsfd_pkg::t_status                     n_s2_status;
    logic signed [hsfd_pkg::TEMP_W-1:0]    n_s2_temp_centi;
    logic [hsfd_pkg::HUM_W-1:0]            n_s2_hum_centi;
    logic [hsfd_pkg::PROD_W-1:0]           temp_prod;
    logic [hsfd_pkg::PROD_W-1:0]           hum_prod;
    logic [hsfd_pkg::QUOT_W-1:0]           temp_quot;
    logic [hsfd_pkg::QUOT_W-1:0]           hum_quot;

    // Advance stage 1 whenever the result register is empty or being drained.
    assign s1_advance = !r_s2_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // Payload registers need no reset; load only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_temp_word  <= i_in.temp_word;
            r_s1_temp_check <= i_in.temp_check;
            r_s1_hum_word   <= i_in.hum_word;
            r_s1_hum_check  <= i_in.hum_check;
        end
    end

    // Scale: raw * span, then exact floor division by full scale.
    assign temp_prod = {{(hsfd_pkg::PROD_W-hsfd_pkg::WORD_W){1'b0}}, r_s1_temp_word}
                       * {{hsfd_pkg::WORD_W{1'b0}}, hsfd_pkg::TEMP_SPAN};
    assign hum_prod  = {{(hsfd_pkg::PROD_W-hsfd_pkg::WORD_W){1'b0}}, r_s1_hum_word}
                       * {{hsfd_pkg::WORD_W{1'b0}}, hsfd_pkg::HUM_SPAN};
    assign temp_quot = hsfd_pkg::div_full_scale(temp_prod);
    assign hum_quot  = hsfd_pkg::div_full_scale(hum_prod);

    // Check temperature first; zero both values on any checksum failure.
    always_comb begin
        n_s2_status     = hsfd_pkg::ST_OK;
        n_s2_temp_centi = '0;
        n_s2_hum_centi  = '0;
        priority if (hsfd_pkg::word_crc(r_s1_temp_word) != r_s1_temp_check) begin
            n_s2_status = hsfd_pkg::ST_TEMP_BAD;
        end else if (hsfd_pkg::word_crc(r_s1_hum_word) != r_s1_hum_check) begin
            n_s2_status = hsfd_pkg::ST_HUM_BAD;
        end else begin
            n_s2_status     = hsfd_pkg::ST_OK;
            n_s2_temp_centi = hsfd_pkg::TEMP_OFFSET + $signed(temp_quot);
            n_s2_hum_centi  = hum_quot[hsfd_pkg::HUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_advance) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    // Hold the result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_s2_status     <= n_s2_status;
            r_s2_temp_centi <= n_s2_temp_centi;
            r_s2_hum_centi  <= n_s2_hum_centi;
        end
    end

    assign o_out.valid      = r_s2_valid;
    assign o_out.status     = r_s2_status;
    assign o_out.temp_centi = r_s2_temp_centi;
    assign o_out.hum_centi  = r_s2_hum_centi;

endmodule
